// File: hw/rtl/scan_elevator_scheduler_defines.svh
// assertion helpers included by scan_elevator_scheduler.sv
`ifndef SCAN_ELEVATOR_SCHEDULER_DEFINES_SVH
`define SCAN_ELEVATOR_SCHEDULER_DEFINES_SVH

// checked only while out of reset
`define SES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SES_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/sesched_pkg.sv
package sesched_pkg;

    localparam int NumFloors  = 16;
    localparam int ReqW       = 16;
    localparam int FloorW     = (NumFloors > 2) ? $clog2(NumFloors) : 1;
    localparam int OutFloorW  = 4;

    typedef logic [ReqW-1:0]      t_req;
    typedef logic [NumFloors-1:0] t_mask;
    typedef logic [FloorW-1:0]    t_floor;

    typedef struct packed {
        t_floor floor;
        logic   up;
        t_mask  calls;
        t_mask  gos;
    } t_state;

    typedef struct packed {
        logic [OutFloorW-1:0] floor_now;
        logic                 arrived;
        logic                 going_up;
        logic                 idle;
    } t_result;

    // requests for floors that do not exist are dropped
    function automatic t_mask to_floors(input t_req req);
        t_mask m;
        m = '0;
        for (int i = 0; i < NumFloors; i++) begin
            if (i < ReqW) begin
                m[i] = req[i % ReqW];
            end
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/scan_elevator_scheduler.sv
// channel  direction  handshake                  payload
// request  in         i_in_valid / o_in_stall    i_new_calls, i_new_gos
// status   out        o_out_valid / i_out_stall  o_floor_now, o_arrived, o_going_up, o_idle
//
// one item per cycle sustained while the status side does not stall; an accepted item passes through
// input register, one-tick scheduler logic, result register
// car state is updated when the item moves from input register to result register
// i_rst_n is synchronous: car on floor 0, heading down, nothing pending, both stages empty
// a stalled result holds the input stage, which then stalls the request side
module scan_elevator_scheduler
    import sesched_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ReqW-1:0]      i_new_calls,
    input  logic [ReqW-1:0]      i_new_gos,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OutFloorW-1:0] o_floor_now,
    output logic                 o_arrived,
    output logic                 o_going_up,
    output logic                 o_idle
);

    `include "scan_elevator_scheduler_defines.svh"

    logic    r_in_valid;
    t_req    r_calls;
    t_req    r_gos;
    logic    r_out_valid;
    t_result r_res;
    t_state  r_st;
    t_state  n_st;
    t_result n_res;
    logic    out_block;
    logic    adv;
    logic    in_acc;
    t_floor  floor_up;
    t_floor  floor_dn;
    logic    near_floor;
    logic    none_pending;

    always_comb begin
        out_block  = r_out_valid & i_out_stall;
        adv        = r_in_valid & ~out_block;
        o_in_stall = r_in_valid & out_block;
        in_acc     = i_in_valid & ~o_in_stall;
    end

    sesched_step u_step (
        .i_st        (r_st),
        .i_new_calls (r_calls),
        .i_new_gos   (r_gos),
        .o_st        (n_st),
        .o_res       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_calls <= i_new_calls;
            r_gos   <= i_new_gos;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_floor_now = r_res.floor_now;
    assign o_arrived   = r_res.arrived;
    assign o_going_up  = r_res.going_up;
    assign o_idle      = r_res.idle;

    // neighbor floors and pending summary for the checks below
    always_comb begin
        floor_up     = t_floor'(r_st.floor + 1'b1);
        floor_dn     = t_floor'(r_st.floor - 1'b1);
        near_floor   = (n_st.floor == r_st.floor) || (n_st.floor == floor_up) ||
                       (n_st.floor == floor_dn);
        none_pending = (r_st.calls == '0) && (r_st.gos == '0);
    end

    `SES_ASSERT(a_floor_step, adv |-> near_floor, "car moved more than one floor")
    `SES_ASSERT(a_idle_match, adv |=> (o_idle == none_pending), "idle flag disagrees with state")
    `SES_ASSERT(a_state_hold, !adv |=> $stable(r_st), "car state changed without an item")
    `SES_ASSERT(a_item_kept, (r_in_valid && !adv) |=> r_in_valid, "item dropped from input stage")

endmodule

// File: hw/rtl/sesched_step.sv
module sesched_step
    import sesched_pkg::*;
(
    input  t_state  i_st,
    input  t_req    i_new_calls,
    input  t_req    i_new_gos,
    output t_state  o_st,
    output t_result o_res
);

    t_mask calls;
    t_mask gos;
    t_mask here;
    t_mask all_req;
    t_mask above;
    t_mask below;
    t_mask ahead;
    logic  served;

    always_comb begin
        here   = t_mask'(1) << i_st.floor;
        calls  = i_st.calls | to_floors(i_new_calls);
        gos    = i_st.gos | to_floors(i_new_gos);
        served = |((calls | gos) & here);
        if (served) begin
            calls = calls & ~here;
            gos   = gos & ~here;
        end
        all_req = calls | gos;
        // strictly above and strictly below the car
        above   = all_req & ~(here | (here - t_mask'(1)));
        below   = all_req & (here - t_mask'(1));
        ahead   = i_st.up ? above : below;

        o_st       = i_st;
        o_st.calls = calls;
        o_st.gos   = gos;
        if (|ahead) begin
            o_st.floor = i_st.up ? t_floor'(i_st.floor + 1'b1)
                                 : t_floor'(i_st.floor - 1'b1);
        end else if (|all_req) begin
            o_st.up = ~i_st.up;
        end

        o_res.floor_now = OutFloorW'(i_st.floor);
        o_res.arrived   = served;
        o_res.going_up  = o_st.up;
        o_res.idle      = ~(|all_req);
    end

endmodule

// File: test/tb.sv
module tb;
    import sesched_pkg::*;

    localparam int DirRows    = 24;
    localparam int RandItems  = 1350;
    localparam int CycleLimit = 200000;

    typedef struct packed {
        t_req    calls;
        t_req    gos;
        logic    typed;
        t_result res;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ReqW-1:0]      i_new_calls;
    logic [ReqW-1:0]      i_new_gos;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [OutFloorW-1:0] o_floor_now;
    logic                 o_arrived;
    logic                 o_going_up;
    logic                 o_idle;

    // car model
    t_floor  car_floor;
    logic    moving_up;
    t_mask   call_pend;
    t_mask   go_pend;

    t_result status_q[$];
    t_result got;
    bit      quiet;
    int      errors;
    int      n_sent;
    int      n_checked;
    int      n_arrived;
    int      n_idle;
    int      cycles = 0;

    // after reset, own-floor service and the first flip are typed in; the rest is predicted
    t_dir_row dir_rows [DirRows] = '{
        {16'h0000, 16'h0000, 1'b1, 4'd0, 1'b0, 1'b0, 1'b1},
        {16'h0001, 16'h0000, 1'b1, 4'd0, 1'b1, 1'b0, 1'b1},
        {16'h0000, 16'h0001, 1'b1, 4'd0, 1'b1, 1'b0, 1'b1},
        {16'h8000, 16'h0000, 1'b1, 4'd0, 1'b0, 1'b1, 1'b0},
        {16'h0000, 16'h0000, 1'b1, 4'd0, 1'b0, 1'b1, 1'b0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'hFFFF, 16'hFFFF, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h8000, 1'b0, 7'd0},
        {16'hAAAA, 16'h5555, 1'b0, 7'd0},
        {16'h5555, 16'hAAAA, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0001, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h4000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0},
        {16'h0000, 16'h0000, 1'b0, 7'd0}
    };

    scan_elevator_scheduler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_new_calls (i_new_calls),
        .i_new_gos   (i_new_gos),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_floor_now (o_floor_now),
        .o_arrived   (o_arrived),
        .o_going_up  (o_going_up),
        .o_idle      (o_idle)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // one floor-time tick of the car
    function automatic t_result scan_tick(input t_req calls, input t_req gos);
        t_result r;
        t_mask   here_bit;
        t_mask   all_req;
        t_mask   above;
        t_mask   below;
        t_floor  f;
        f = car_floor;
        here_bit = t_mask'(1) << f;
        call_pend = call_pend | t_mask'(calls);
        go_pend = go_pend | t_mask'(gos);
        r.arrived = ((call_pend | go_pend) & here_bit) != '0;
        if (r.arrived) begin
            call_pend = call_pend & ~here_bit;
            go_pend = go_pend & ~here_bit;
        end
        all_req = call_pend | go_pend;
        above = all_req & ~((t_mask'(2) << f) - t_mask'(1));
        below = all_req & (here_bit - t_mask'(1));
        if (moving_up ? (above != '0) : (below != '0)) begin
            car_floor = moving_up ? t_floor'(f + 1'b1) : t_floor'(f - 1'b1);
        end else if (all_req != '0) begin
            moving_up = !moving_up;
        end
        r.floor_now = OutFloorW'(f);
        r.going_up = moving_up;
        r.idle = (all_req == '0);
        return r;
    endfunction

    task automatic send_tick(input t_req calls, input t_req gos, input logic typed,
                             input t_result typed_res);
        t_result pred;
        while (!quiet && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_new_calls <= calls;
        i_new_gos   <= gos;
        do @(posedge i_clk); while (o_in_stall);
        pred = scan_tick(calls, gos);
        status_q.push_back(typed ? typed_res : pred);
        n_sent++;
    endtask

    // status side: check each item, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $error("status item with nothing expected");
                    errors++;
                end else begin
                    got = status_q.pop_front();
                    if (o_floor_now !== got.floor_now) begin
                        $error("floor_now: expected %0d, got %0d", got.floor_now, o_floor_now);
                        errors++;
                    end
                    if (o_arrived !== got.arrived) begin
                        $error("arrived: expected %0b, got %0b", got.arrived, o_arrived);
                        errors++;
                    end
                    if (o_going_up !== got.going_up) begin
                        $error("going_up: expected %0b, got %0b", got.going_up, o_going_up);
                        errors++;
                    end
                    if (o_idle !== got.idle) begin
                        $error("idle: expected %0b, got %0b", got.idle, o_idle);
                        errors++;
                    end
                    n_checked++;
                    if (o_arrived === 1'b1) n_arrived++;
                    if (o_idle === 1'b1) n_idle++;
                end
            end
            i_out_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("scan_elevator_scheduler test failed");
            $finish;
        end
    end

    initial begin
        t_req    calls;
        t_req    gos;
        int      pick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_new_calls = '0;
        i_new_gos   = '0;
        quiet       = 1'b0;
        errors      = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_arrived   = 0;
        n_idle      = 0;
        car_floor   = '0;
        moving_up   = 1'b0;
        call_pend   = '0;
        go_pend     = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DirRows; i++) begin
            send_tick(dir_rows[i].calls, dir_rows[i].gos, dir_rows[i].typed, dir_rows[i].res);
        end

        for (int n = 0; n < RandItems; n++) begin
            quiet = (n >= 500 && n < 800);
            if (n == 900) begin
                // let the pipe drain completely before carrying on
                i_in_valid <= 1'b0;
                while (status_q.size() != 0) @(posedge i_clk);
            end
            pick  = $urandom_range(99);
            calls = '0;
            gos   = '0;
            // mostly empty ticks and single requests so the car travels and sweeps
            if (pick < 55) begin
                calls = '0;
            end else if (pick < 80) begin
                if ($urandom_range(1) == 1) calls = t_req'(1) << $urandom_range(ReqW - 1);
                else gos = t_req'(1) << $urandom_range(ReqW - 1);
            end else if (pick < 92) begin
                calls = t_req'(1) << $urandom_range(ReqW - 1);
                gos   = t_req'(1) << $urandom_range(ReqW - 1);
            end else begin
                calls = t_req'($urandom);
                gos   = t_req'($urandom);
            end
            send_tick(calls, gos, 1'b0, '0);
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("sent %0d ticks (directed and random, with a drain pause), checked %0d",
                 n_sent, n_checked);
        $display("car served %0d requests, %0d ticks ended idle", n_arrived, n_idle);
        if (errors == 0) begin
            $display("scan_elevator_scheduler test passed");
        end else begin
            $display("scan_elevator_scheduler test failed");
        end
        $finish;
    end

endmodule
